// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop, clk, rstn)
`define ASSERT_NEVER(lbl, expr, clk, rstn)

`endif

`endif

// ===== hw/rtl/petm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// petm_pkg
// Shared types and constants of the packet error tolerance monitor.
// ----------------------------------------------------------------------------
package petm_pkg;

  localparam int unsigned WINDOW_PACKETS_DEF   = 10;
  localparam int unsigned MAX_CHECK_LENGTH_DEF = 4095;

  localparam int unsigned CNT_W   = 12;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CFG_W   = 16;

  localparam logic [7:0]         GOOD_BYTE = 8'hFF;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [LEVEL_W-1:0] TOL_BASE  = 16'd50;
  localparam logic [LEVEL_W-1:0] OVH_BASE  = 16'd100;

  typedef enum logic [1:0] {
    REG_CHECK_LENGTH   = 2'd0,
    REG_TOLERANCE_INIT = 2'd1,
    REG_OVERHEAD_INIT  = 2'd2,
    REG_ADAPTIVE_MODE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               done;
    logic [CNT_W-1:0]   min_errs;
    logic [CNT_W-1:0]   max_errs;
    logic [LEVEL_W-1:0] avg;
  } win_stat_t;

endpackage

// ===== hw/rtl/petm_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// petm_window
// Per-window min, max and error sum, with the window average at its close.
// ----------------------------------------------------------------------------
module petm_window #(
  parameter int unsigned WINDOW_PACKETS = petm_pkg::WINDOW_PACKETS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         update_i,
  input  logic [petm_pkg::CNT_W-1:0]   errs_i,
  output petm_pkg::win_stat_t          stat_o
);

  // floor(sum / WINDOW_PACKETS) as a reciprocal multiply, exact for 16 bit sums
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(WINDOW_PACKETS) - 64'd1) / 64'(WINDOW_PACKETS));
  localparam logic [petm_pkg::SLOT_W-1:0] WinLen = petm_pkg::SLOT_W'(WINDOW_PACKETS);

  logic [petm_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [petm_pkg::LEVEL_W-1:0] sum_q, sum_d;
  logic [petm_pkg::CNT_W-1:0]   min_q, min_d, max_q, max_d;

  logic                                        first;
  logic [petm_pkg::SLOT_W-1:0]                 slot_inc;
  logic [petm_pkg::LEVEL_W+RecipW-1:0]         prod;

  always_comb begin
    first    = (slot_q == '0) || (slot_q >= WinLen);
    slot_inc = (first ? '0 : slot_q) + petm_pkg::SLOT_W'(1);
    if (first) begin
      min_d = errs_i;
      max_d = errs_i;
      sum_d = petm_pkg::LEVEL_W'(errs_i);
    end else begin
      min_d = (errs_i < min_q) ? errs_i : min_q;
      max_d = (errs_i > max_q) ? errs_i : max_q;
      sum_d = sum_q + petm_pkg::LEVEL_W'(errs_i);
    end
    stat_o.done     = (slot_inc >= WinLen);
    slot_d          = stat_o.done ? '0 : slot_inc;
    prod            = (petm_pkg::LEVEL_W+RecipW)'(sum_d) * (petm_pkg::LEVEL_W+RecipW)'(Recip);
    stat_o.min_errs = min_d;
    stat_o.max_errs = max_d;
    stat_o.avg      = stat_o.done ? prod[RecipShift +: petm_pkg::LEVEL_W] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      sum_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else if (update_i) begin
      slot_q <= slot_d;
      sum_q  <= sum_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

endmodule

// ===== hw/rtl/packet_error_tolerance_monitor.sv =====
`timescale 1ns / 1ps
// result path: a last byte's result passes the input register, then the result
// register; other bytes give no result
// throughput: one byte per cycle, stalls only while a finished result waits
// and the next registered byte is also a last byte
// reset: asynchronous, clears all levels, counters, window state and totals
// ----------------------------------------------------------------------------
// packet_error_tolerance_monitor
// Counts byte errors per packet, checks them against an adaptive tolerance,
// keeps a usable byte total and per-window error statistics.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_error_tolerance_monitor #(
  parameter int unsigned WINDOW_PACKETS   = petm_pkg::WINDOW_PACKETS_DEF,
  parameter int unsigned MAX_CHECK_LENGTH = petm_pkg::MAX_CHECK_LENGTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pkt_pass_o,
  output logic [petm_pkg::CNT_W-1:0]     error_count_o,
  output logic [petm_pkg::TOTAL_W-1:0]   byte_total_o,
  output logic                           window_done_o,
  output logic [petm_pkg::CNT_W-1:0]     window_min_o,
  output logic [petm_pkg::CNT_W-1:0]     window_max_o,
  output logic [petm_pkg::CNT_W-1:0]     window_avg_o,
  output logic [petm_pkg::LEVEL_W-1:0]   tolerance_now_o,
  output logic [petm_pkg::LEVEL_W-1:0]   overhead_now_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [petm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam logic [petm_pkg::LEVEL_W-1:0] MaxLen = petm_pkg::LEVEL_W'(MAX_CHECK_LENGTH);

  // config and state
  logic [petm_pkg::CNT_W-1:0]   check_len_q, check_len_d;
  logic                         adaptive_q, adaptive_d;
  logic [petm_pkg::LEVEL_W-1:0] tol_q, tol_d, ovh_q, ovh_d;
  logic [petm_pkg::CNT_W-1:0]   pos_q, pos_d, perr_q, perr_d;
  logic [petm_pkg::TOTAL_W-1:0] total_q, total_d;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_go, fire, in_accept, close_pkt;

  // result stage
  logic                         out_valid_q, out_valid_d;
  logic                         r_ok_q, r_done_q;
  logic [petm_pkg::CNT_W-1:0]   r_errs_q, r_min_q, r_max_q, r_avg_q;
  logic [petm_pkg::TOTAL_W-1:0] r_total_q;
  logic [petm_pkg::LEVEL_W-1:0] r_tol_q, r_ovh_q;

  // byte checks
  logic [petm_pkg::CNT_W-1:0]   len, perr_inc, errs;
  logic [petm_pkg::CNT_W:0]     count, gap;
  logic [petm_pkg::CNT_W+1:0]   errs_sum;
  logic                         ok;
  logic [petm_pkg::LEVEL_W:0]   tol_calc, ovh_calc;
  logic                         cfg_we;
  petm_pkg::cfg_reg_e           cfg_reg;
  petm_pkg::win_stat_t          stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_reg     = petm_pkg::cfg_reg_e'(cfg_index_i);

  // a non-last byte never needs the result register
  assign s1_go      = !s1_last_q || !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s1_go;
  assign close_pkt  = fire && s1_last_q;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    len      = ({4'b0, check_len_q} > MaxLen) ? MaxLen[petm_pkg::CNT_W-1:0] : check_len_q;
    perr_inc = perr_q;
    if ((pos_q < len) && (s1_data_q != petm_pkg::GOOD_BYTE) && (perr_q != petm_pkg::CNT_MAX)) begin
      perr_inc = perr_q + petm_pkg::CNT_W'(1);
    end
    // positions past the packet end, up to the check length, count as errors
    count    = {1'b0, pos_q} + (petm_pkg::CNT_W+1)'(1);
    gap      = ({1'b0, len} > count) ? ({1'b0, len} - count) : '0;
    errs_sum = {2'b0, perr_inc} + {1'b0, gap};
    errs     = (errs_sum > {2'b0, petm_pkg::CNT_MAX}) ? petm_pkg::CNT_MAX
                                                     : errs_sum[petm_pkg::CNT_W-1:0];
    ok       = ({4'b0, errs} <= tol_q);
    tol_calc = {stat.avg, 1'b0} + {1'b0, petm_pkg::TOL_BASE};
    ovh_calc = {tol_calc[petm_pkg::LEVEL_W-2:0], 1'b0} + {1'b0, petm_pkg::OVH_BASE};

    pos_d       = pos_q;
    perr_d      = perr_q;
    total_d     = total_q;
    tol_d       = tol_q;
    ovh_d       = ovh_q;
    check_len_d = check_len_q;
    adaptive_d  = adaptive_q;

    if (fire) begin
      if (s1_last_q) begin
        pos_d  = '0;
        perr_d = '0;
        if (ok && ({4'b0, len} > ovh_q)) begin
          total_d = total_q + petm_pkg::TOTAL_W'(len - ovh_q[petm_pkg::CNT_W-1:0]);
        end
        if (stat.done && adaptive_q) begin
          tol_d = tol_calc[petm_pkg::LEVEL_W-1:0];
          ovh_d = ovh_calc[petm_pkg::LEVEL_W-1:0];
        end
      end else begin
        pos_d  = (pos_q == petm_pkg::CNT_MAX) ? pos_q : pos_q + petm_pkg::CNT_W'(1);
        perr_d = perr_inc;
      end
    end

    if (cfg_we) begin
      unique case (cfg_reg)
        petm_pkg::REG_CHECK_LENGTH:   check_len_d = cfg_data_i[petm_pkg::CNT_W-1:0];
        petm_pkg::REG_TOLERANCE_INIT: tol_d       = cfg_data_i;
        petm_pkg::REG_OVERHEAD_INIT:  ovh_d       = cfg_data_i;
        petm_pkg::REG_ADAPTIVE_MODE:  adaptive_d  = cfg_data_i[0];
      endcase
    end

    s1_valid_d = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
    out_valid_d = close_pkt ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  petm_window #(
    .WINDOW_PACKETS (WINDOW_PACKETS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (close_pkt),
    .errs_i   (errs),
    .stat_o   (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_len_q <= '0;
      adaptive_q  <= 1'b0;
      tol_q       <= '0;
      ovh_q       <= '0;
      pos_q       <= '0;
      perr_q      <= '0;
      total_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      check_len_q <= check_len_d;
      adaptive_q  <= adaptive_d;
      tol_q       <= tol_d;
      ovh_q       <= ovh_d;
      pos_q       <= pos_d;
      perr_q      <= perr_d;
      total_q     <= total_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (close_pkt) begin
      r_ok_q    <= ok;
      r_errs_q  <= errs;
      r_total_q <= total_d;
      r_done_q  <= stat.done;
      r_min_q   <= stat.min_errs;
      r_max_q   <= stat.max_errs;
      r_avg_q   <= stat.avg[petm_pkg::CNT_W-1:0];
      r_tol_q   <= tol_d;
      r_ovh_q   <= ovh_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pkt_pass_o      = r_ok_q;
  assign error_count_o   = r_errs_q;
  assign byte_total_o    = r_total_q;
  assign window_done_o   = r_done_q;
  assign window_min_o    = r_min_q;
  assign window_max_o    = r_max_q;
  assign window_avg_o    = r_avg_q;
  assign tolerance_now_o = r_tol_q;
  assign overhead_now_o  = r_ovh_q;

  `ASSERT_PROP(a_result_from_last, $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q), clk_i, rst_ni)
  `ASSERT_PROP(a_packet_restart, close_pkt |=> (pos_q == '0 && perr_q == '0), clk_i, rst_ni)
  `ASSERT_PROP(a_hold_last_beat, (out_valid_q && out_stall_i && s1_valid_q && s1_last_q) |-> in_stall_o, clk_i, rst_ni)
  `ASSERT_NEVER(a_avg_only_at_close, out_valid_q && !r_done_q && (r_avg_q != '0), clk_i, rst_ni)

endmodule

// ===== tb/tb_packet_error_tolerance_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_error_tolerance_monitor
// Drives packet bytes with random gaps and result back-pressure, keeps its own
// model of per-packet error counting, tolerance, byte totals and window
// statistics, and checks every packet verdict field by field.
// ----------------------------------------------------------------------------
module tb_packet_error_tolerance_monitor;

  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_BYTES  = 1020;
  localparam int unsigned MAX_RAND_LEN  = 64;

  typedef struct {
    logic                         ok;
    logic [petm_pkg::CNT_W-1:0]   errs;
    logic [petm_pkg::TOTAL_W-1:0] total;
    logic                         done;
    logic [petm_pkg::CNT_W-1:0]   wmin;
    logic [petm_pkg::CNT_W-1:0]   wmax;
    logic [petm_pkg::CNT_W-1:0]   wavg;
    logic [petm_pkg::LEVEL_W-1:0] tol;
    logic [petm_pkg::LEVEL_W-1:0] ovh;
  } verdict_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     data_byte_i = '0;
  logic                           last_byte_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           pkt_pass_o;
  logic [petm_pkg::CNT_W-1:0]     error_count_o;
  logic [petm_pkg::TOTAL_W-1:0]   byte_total_o;
  logic                           window_done_o;
  logic [petm_pkg::CNT_W-1:0]     window_min_o;
  logic [petm_pkg::CNT_W-1:0]     window_max_o;
  logic [petm_pkg::CNT_W-1:0]     window_avg_o;
  logic [petm_pkg::LEVEL_W-1:0]   tolerance_now_o;
  logic [petm_pkg::LEVEL_W-1:0]   overhead_now_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  petm_pkg::cfg_reg_e             cfg_index_i = petm_pkg::REG_CHECK_LENGTH;
  logic [petm_pkg::CFG_W-1:0]     cfg_data_i = '0;

  // model state
  logic [petm_pkg::CNT_W-1:0]     chk_len;
  logic                           adaptive;
  logic [petm_pkg::CNT_W-1:0]     byte_pos;
  logic [petm_pkg::CNT_W-1:0]     pkt_errs;
  logic [petm_pkg::LEVEL_W-1:0]   tol_lvl;
  logic [petm_pkg::LEVEL_W-1:0]   ovh_lvl;
  logic [petm_pkg::SLOT_W-1:0]    win_slot;
  logic [15:0]                    win_sum;
  logic [petm_pkg::CNT_W-1:0]     win_min;
  logic [petm_pkg::CNT_W-1:0]     win_max;
  logic [petm_pkg::TOTAL_W-1:0]   usable_total;

  verdict_t             verdict_q[$];

  bit                   idle_on;
  int unsigned          hold_cycles;
  int unsigned          stall_left;
  int unsigned          quiet_cycles;
  int unsigned          mismatches;
  int unsigned          bytes_sent;
  int unsigned          rand_bytes;
  int unsigned          packets_checked;
  int unsigned          windows_seen;
  int unsigned          reg_writes;

  packet_error_tolerance_monitor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pkt_pass_o      (pkt_pass_o),
    .error_count_o   (error_count_o),
    .byte_total_o    (byte_total_o),
    .window_done_o   (window_done_o),
    .window_min_o    (window_min_o),
    .window_max_o    (window_max_o),
    .window_avg_o    (window_avg_o),
    .tolerance_now_o (tolerance_now_o),
    .overhead_now_o  (overhead_now_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // error and window model
  // ---------------------------------------------------------------------------
  function automatic logic [petm_pkg::CNT_W-1:0] sat_add(input int unsigned a,
                                                         input int unsigned b);
    return (a + b > petm_pkg::CNT_MAX) ? petm_pkg::CNT_MAX : petm_pkg::CNT_W'(a + b);
  endfunction

  task automatic apply_reg(input petm_pkg::cfg_reg_e idx,
                           input logic [petm_pkg::CFG_W-1:0] val);
    case (idx)
      petm_pkg::REG_CHECK_LENGTH:   chk_len = val[petm_pkg::CNT_W-1:0];
      petm_pkg::REG_TOLERANCE_INIT: tol_lvl = val[petm_pkg::LEVEL_W-1:0];
      petm_pkg::REG_OVERHEAD_INIT:  ovh_lvl = val[petm_pkg::LEVEL_W-1:0];
      petm_pkg::REG_ADAPTIVE_MODE:  adaptive = val[0];
      default: ;
    endcase
  endtask

  task automatic score_byte(input logic [7:0] data, input logic last);
    int unsigned len;
    int unsigned cnt;
    int unsigned e;
    int unsigned avg;
    verdict_t v;
    len = chk_len;
    if (byte_pos < len && data != petm_pkg::GOOD_BYTE) pkt_errs = sat_add(pkt_errs, 1);
    if (!last) begin
      if (byte_pos != petm_pkg::CNT_MAX) byte_pos++;
      return;
    end
    // positions missing from a short packet count as errors
    cnt = byte_pos + 1;
    if (len > cnt) pkt_errs = sat_add(pkt_errs, len - cnt);
    e = pkt_errs;
    byte_pos = '0;
    pkt_errs = '0;
    v.ok = (e <= tol_lvl);
    if (v.ok && len > ovh_lvl)
      usable_total = usable_total + petm_pkg::TOTAL_W'(len - ovh_lvl);
    if (win_slot == 0 || win_slot >= petm_pkg::WINDOW_PACKETS_DEF) begin
      win_slot = '0;
      win_min = petm_pkg::CNT_W'(e);
      win_max = petm_pkg::CNT_W'(e);
      win_sum = 16'(e);
    end else begin
      if (e < win_min) win_min = petm_pkg::CNT_W'(e);
      if (e > win_max) win_max = petm_pkg::CNT_W'(e);
      win_sum = win_sum + 16'(e);
    end
    win_slot++;
    avg = 0;
    v.done = 1'b0;
    if (win_slot >= petm_pkg::WINDOW_PACKETS_DEF) begin
      v.done = 1'b1;
      win_slot = '0;
      avg = win_sum / petm_pkg::WINDOW_PACKETS_DEF;
      if (adaptive) begin
        tol_lvl = petm_pkg::LEVEL_W'(avg * 2 + petm_pkg::TOL_BASE);
        ovh_lvl = petm_pkg::LEVEL_W'(tol_lvl * 2 + petm_pkg::OVH_BASE);
      end
    end
    v.errs  = petm_pkg::CNT_W'(e);
    v.total = usable_total;
    v.wmin  = win_min;
    v.wmax  = win_max;
    v.wavg  = petm_pkg::CNT_W'(avg);
    v.tol   = tol_lvl;
    v.ovh   = ovh_lvl;
    verdict_q.push_back(v);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_bad(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) report_bad(what, want, got);
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        report_bad("unexpected result beat", '0, 64'(error_count_o));
      end else begin
        want = verdict_q.pop_front();
        check_field("pkt_pass", want.ok, pkt_pass_o);
        check_field("error_count", want.errs, error_count_o);
        check_field("byte_total", want.total, byte_total_o);
        check_field("window_done", want.done, window_done_o);
        check_field("window_min", want.wmin, window_min_o);
        check_field("window_max", want.wmax, window_max_o);
        check_field("window_avg", want.wavg, window_avg_o);
        check_field("tolerance_now", want.tol, tolerance_now_o);
        check_field("overhead_now", want.ovh, overhead_now_o);
        packets_checked++;
        if (want.done) windows_seen++;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
        $display("** packet_error_tolerance_monitor: FAILED **");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic last);
    @(negedge clk_i);
    if (idle_on && $urandom_range(7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    score_byte(data, last);
    bytes_sent++;
  endtask

  task automatic send_run(input int unsigned n, input int unsigned err_pct, input bit close);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(99) < err_pct) ? 8'($urandom_range(254)) : petm_pkg::GOOD_BYTE;
      send_byte(b, close && (i == n - 1));
    end
  endtask

  // stop sending and let every byte in flight and every result drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input petm_pkg::cfg_reg_e idx,
                           input logic [petm_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [petm_pkg::CFG_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(65535));
      4:       return 16'($urandom_range(4095));
      default: return 16'($urandom_range(12));
    endcase
  endfunction

  // upper data bits are don't-care for the check length, toggle them anyway
  function automatic logic [petm_pkg::CFG_W-1:0] pick_check_length();
    case ($urandom_range(9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(65535));
      2, 3:    return 16'($urandom_range(25, 200));
      default: return 16'($urandom_range(24));
    endcase
  endfunction

  task automatic write_random_reg(input petm_pkg::cfg_reg_e idx);
    case (idx)
      petm_pkg::REG_CHECK_LENGTH:  write_reg(idx, pick_check_length());
      petm_pkg::REG_ADAPTIVE_MODE: write_reg(idx, 16'($urandom_range(65535)));
      default:                     write_reg(idx, pick_level());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    // zero check length: nothing is checked, nothing is usable
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_basic_errors();
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'd4);
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'd1);
    write_reg(petm_pkg::REG_OVERHEAD_INIT, 16'd2);
    write_reg(petm_pkg::REG_ADAPTIVE_MODE, 16'd0);
    for (int i = 0; i < 4; i++) send_byte(petm_pkg::GOOD_BYTE, i == 3);
    send_byte(8'h00, 1'b1);
    // bad bytes past the checked length are ignored
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    // overhead equal to the length adds nothing
    wait_idle();
    write_reg(petm_pkg::REG_OVERHEAD_INIT, 16'd4);
    for (int i = 0; i < 4; i++) send_byte(petm_pkg::GOOD_BYTE, i == 3);
    wait_idle();
  endtask

  task automatic test_midpacket_write();
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'd6);
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'd3);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_extremes();
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'hFFFF);
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'hFFFF);
    write_reg(petm_pkg::REG_OVERHEAD_INIT, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    wait_idle();
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'h0000);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'hFFFF);
    write_reg(petm_pkg::REG_OVERHEAD_INIT, 16'h0000);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'h0000);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_window_adaptive();
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'd3);
    write_reg(petm_pkg::REG_TOLERANCE_INIT, 16'd0);
    write_reg(petm_pkg::REG_OVERHEAD_INIT, 16'd0);
    write_reg(petm_pkg::REG_ADAPTIVE_MODE, 16'd1);
    for (int i = 0; i < 2 * petm_pkg::WINDOW_PACKETS_DEF + 3; i++)
      send_run($urandom_range(1, 4), 40, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    bit keep_idle;
    keep_idle = idle_on;
    idle_on = 1'b0;
    write_reg(petm_pkg::REG_CHECK_LENGTH, 16'd2);
    @(posedge clk_i);
    hold_cycles = HOLD_CYCLES;
    // short packets keep the result path full so the input side stalls
    for (int i = 0; i < 30; i++) send_run($urandom_range(1, 2), 30, 1'b1);
    wait_idle();
    idle_on = keep_idle;
  endtask

  task automatic test_random_traffic();
    int unsigned npkt;
    int unsigned len;
    int unsigned pkt_len;
    int unsigned pct;
    int unsigned start;
    int unsigned split;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start > RANDOM_BYTES * 4 / 5) idle_on = 1'b0;
      wait_idle();
      write_random_reg(petm_pkg::cfg_reg_e'($urandom_range(3)));
      for (int r = 0; r < 4; r++)
        if ($urandom_range(1) == 0) write_random_reg(petm_pkg::cfg_reg_e'(r));
      npkt = $urandom_range(5, 25);
      for (int p = 0; p < npkt; p++) begin
        len = chk_len;
        if (len + 2 <= MAX_RAND_LEN && $urandom_range(9) < 7)
          pkt_len = $urandom_range((len > 2) ? len - 2 : 1, len + 2);
        else
          pkt_len = $urandom_range(1, (len + 8 < MAX_RAND_LEN) ? len + 8 : MAX_RAND_LEN);
        if (pkt_len == 0) pkt_len = 1;
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 60;
          default: pct = 8;
        endcase
        if (pkt_len >= 2 && $urandom_range(11) == 0) begin
          split = $urandom_range(1, pkt_len - 1);
          send_run(split, pct, 1'b0);
          wait_idle();
          write_random_reg(petm_pkg::cfg_reg_e'($urandom_range(3)));
          send_run(pkt_len - split, pct, 1'b1);
        end else begin
          send_run(pkt_len, pct, 1'b1);
        end
        if ($urandom_range(15) == 0) wait_idle();
      end
    end
    rand_bytes = bytes_sent - start;
  endtask

  initial begin
    chk_len = '0;
    adaptive = 1'b0;
    byte_pos = '0;
    pkt_errs = '0;
    tol_lvl = '0;
    ovh_lvl = '0;
    win_slot = '0;
    win_sum = '0;
    win_min = '0;
    win_max = '0;
    usable_total = '0;
    idle_on = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_basic_errors();
    test_midpacket_write();
    test_extremes();
    test_window_adaptive();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes (%0d random), %0d packets, %0d windows, %0d register writes",
             bytes_sent, rand_bytes, packets_checked, windows_seen, reg_writes);
    $display("mismatches: %0d, results still pending: %0d", mismatches, verdict_q.size());
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("** packet_error_tolerance_monitor: PASSED **");
    else
      $display("** packet_error_tolerance_monitor: FAILED **");
    $finish;
  end

endmodule
